// File: rtl/core/sclut_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the subtitle colour lookup unit.
// No dependencies.

package sclut_pkg;

  localparam int ClutEntries = 276;
  localparam int AddrW       = 9;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [1:0] DEPTH_TWO   = 2'd0;
  localparam logic [1:0] DEPTH_FOUR  = 2'd1;
  localparam logic [1:0] DEPTH_EIGHT = 2'd2;
  localparam logic [1:0] DEPTH_NONE  = 2'd3;

  localparam logic [1:0] SRC_EXACT   = 2'd0;
  localparam logic [1:0] SRC_FIRST   = 2'd1;
  localparam logic [1:0] SRC_SECOND  = 2'd2;
  localparam logic [1:0] SRC_DEFAULT = 2'd3;

  localparam logic [1:0] CFG_MAP_2_TO_4     = 2'd0;
  localparam logic [1:0] CFG_MAP_2_TO_8     = 2'd1;
  localparam logic [1:0] CFG_MAP_4_TO_8_LOW = 2'd2;
  localparam logic [1:0] CFG_MAP_4_TO_8_HI  = 2'd3;

  localparam logic [15:0] MAP_2_TO_4_RST     = 16'hF870;
  localparam logic [31:0] MAP_2_TO_8_RST     = 32'hFF887700;
  localparam logic [63:0] MAP_4_TO_8_LOW_RST = 64'h7766554433221100;
  localparam logic [63:0] MAP_4_TO_8_HI_RST  = 64'hFFEEDDCCBBAA9988;

  typedef logic [AddrW-1:0] clut_addr_t;
  typedef logic [31:0]      rgba_t;

  // Memory word: valid mark above the packed colour
  typedef struct packed {
    logic  valid;
    rgba_t colour;
  } clut_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXACT,
    ST_ALT1,
    ST_ALT2
  } sclut_state_t;

  localparam clut_addr_t ClutLast = clut_addr_t'(ClutEntries - 1);

  // Memory layout: eight-bit table at 0, four-bit at 256, two-bit at 272
  function automatic clut_addr_t clut_addr(input logic [1:0] depth, input logic [7:0] idx);
    clut_addr_t a;
    case (depth)
      DEPTH_TWO:  a = {7'b1000100, idx[1:0]};
      DEPTH_FOUR: a = {5'b10000, idx[3:0]};
      default:    a = {1'b0, idx};
    endcase
    return a;
  endfunction

  function automatic logic [1:0] reduce_4_to_2(input logic [3:0] k);
    logic [1:0] r;
    if (k == 4'd0) begin
      r = 2'd0;
    end else if (k == 4'd8) begin
      r = 2'd2;
    end else begin
      r = k[3] ? 2'd3 : 2'd1;
    end
    return r;
  endfunction

  // 255 * p / 100, truncated, for the percentages the defaults use
  function automatic logic [7:0] scale_pct(input logic [6:0] p);
    logic [7:0] v;
    case (p)
      7'd17:   v = 8'd43;
      7'd25:   v = 8'd63;
      7'd33:   v = 8'd84;
      7'd50:   v = 8'd127;
      7'd67:   v = 8'd170;
      7'd83:   v = 8'd211;
      7'd100:  v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic rgba_t default_colour(input logic [1:0] depth, input logic [7:0] idx);
    logic [6:0] r;
    logic [6:0] g;
    logic [6:0] b;
    logic [6:0] a;
    logic [6:0] lvl;
    logic [6:0] half;
    r = 7'd0;
    g = 7'd0;
    b = 7'd0;
    a = 7'd0;
    lvl = 7'd0;
    half = 7'd0;
    case (depth)
      DEPTH_TWO: begin
        a = (idx[1:0] == 2'd0) ? 7'd0 : 7'd100;
        lvl = (idx[1:0] == 2'd1) ? 7'd100 : ((idx[1:0] == 2'd3) ? 7'd50 : 7'd0);
        r = lvl;
        g = lvl;
        b = lvl;
      end
      DEPTH_FOUR: begin
        if (idx[3:0] != 4'd0) begin
          lvl = idx[3] ? 7'd50 : 7'd100;
          r = idx[0] ? lvl : 7'd0;
          g = idx[1] ? lvl : 7'd0;
          b = idx[2] ? lvl : 7'd0;
          a = 7'd100;
        end
      end
      DEPTH_EIGHT: begin
        if (idx == 8'd0) begin
          a = 7'd0;
        end else if (idx[7:3] == 5'd0) begin
          r = idx[0] ? 7'd100 : 7'd0;
          g = idx[1] ? 7'd100 : 7'd0;
          b = idx[2] ? 7'd100 : 7'd0;
          a = 7'd25;
        end else if (!idx[7]) begin
          r = (idx[0] ? 7'd33 : 7'd0) + (idx[4] ? 7'd67 : 7'd0);
          g = (idx[1] ? 7'd33 : 7'd0) + (idx[5] ? 7'd67 : 7'd0);
          b = (idx[2] ? 7'd33 : 7'd0) + (idx[6] ? 7'd67 : 7'd0);
          a = idx[3] ? 7'd50 : 7'd100;
        end else begin
          half = idx[3] ? 7'd0 : 7'd50;
          r = (idx[0] ? 7'd17 : 7'd0) + (idx[4] ? 7'd33 : 7'd0) + half;
          g = (idx[1] ? 7'd17 : 7'd0) + (idx[5] ? 7'd33 : 7'd0) + half;
          b = (idx[2] ? 7'd17 : 7'd0) + (idx[6] ? 7'd33 : 7'd0) + half;
          a = 7'd100;
        end
      end
      default: begin
        a = 7'd0;
      end
    endcase
    return {scale_pct(a), scale_pct(b), scale_pct(g), scale_pct(r)};
  endfunction

endpackage

// File: rtl/core/subtitle_clut_lookup_with_fallback_unit.sv
`timescale 1ns / 1ps
// Top level of the subtitle colour lookup unit: CLUT memory, valid bits, fallback resolution.
// Depends on sclut_pkg.

// After reset a clearing pass marks every table entry invalid, with busy high throughout.
// A write, or a lookup with depth code three, leaves busy low; that lookup's result is
// strobed on out_valid in the cycle after it was accepted. Any other lookup reads the
// single colour memory, valid mark included, once per candidate entry in turn (exact,
// first alternate, second alternate), with busy high from the accept until the state
// machine returns to idle. The registered result is strobed when an exact entry, a first
// alternate or else the second alternate or default decides it. The receiver cannot
// hold results off, so nothing else stalls.
module subtitle_clut_lookup_with_fallback_unit
  import sclut_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [1:0]  in_depth_code,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [1:0]  out_colour_source
);

  clut_word_t             clut_mem [ClutEntries];
  logic [15:0]            map24_r;
  logic [31:0]            map28_r;
  logic [63:0]            map48_lo_r;
  logic [63:0]            map48_hi_r;

  sclut_state_t           state_r;
  sclut_state_t           state_nxt;
  clut_addr_t             clr_addr_r;
  clut_addr_t             clr_addr_nxt;
  logic [1:0]             depth_r;
  logic [7:0]             idx_r;
  clut_addr_t             alt1_r;
  clut_addr_t             alt2_r;
  clut_word_t             rd_word_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [1:0]             src_r;
  logic [1:0]             src_nxt;
  rgba_t                  colour_r;
  rgba_t                  colour_nxt;

  logic                   accept;
  logic                   mem_we;
  clut_addr_t             mem_waddr;
  clut_word_t             mem_wdata;
  clut_addr_t             mem_raddr;
  clut_addr_t             exact_addr;
  clut_addr_t             alt1_addr;
  clut_addr_t             alt2_addr;
  logic [7:0]             map48_byte;
  rgba_t                  dflt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign exact_addr = clut_addr(in_depth_code, in_entry_index);
  assign map48_byte = in_entry_index[3] ? map48_hi_r[in_entry_index[2:0]*8 +: 8]
                                        : map48_lo_r[in_entry_index[2:0]*8 +: 8];
  assign dflt       = default_colour(depth_r, idx_r);

  always_comb begin
    case (in_depth_code)
      DEPTH_TWO: begin
        alt1_addr = clut_addr(DEPTH_FOUR, {4'd0, map24_r[in_entry_index[1:0]*4 +: 4]});
        alt2_addr = clut_addr(DEPTH_EIGHT, map28_r[in_entry_index[1:0]*8 +: 8]);
      end
      DEPTH_FOUR: begin
        alt1_addr = clut_addr(DEPTH_EIGHT, map48_byte);
        alt2_addr = clut_addr(DEPTH_TWO, {6'd0, reduce_4_to_2(in_entry_index[3:0])});
      end
      default: begin
        alt1_addr = clut_addr(DEPTH_FOUR, in_entry_index);
        alt2_addr = clut_addr(DEPTH_TWO, {6'd0, reduce_4_to_2(in_entry_index[3:0])});
      end
    endcase
  end

  // one transaction at a time, so a read never overlaps a write to the same entry
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    src_nxt       = src_r;
    colour_nxt    = colour_r;
    mem_we        = 1'b0;
    mem_waddr     = exact_addr;
    mem_wdata     = {1'b1, in_alpha, in_blue, in_green, in_red};
    mem_raddr     = exact_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ClutLast) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_WRITE) begin
            mem_we = (in_depth_code != DEPTH_NONE);
          end else if (in_depth_code == DEPTH_NONE) begin
            out_valid_nxt = 1'b1;
            src_nxt       = SRC_DEFAULT;
            colour_nxt    = '0;
          end else begin
            state_nxt = ST_EXACT;
          end
        end
      end
      ST_EXACT: begin
        mem_raddr = alt1_r;
        if (rd_word_r.valid) begin
          out_valid_nxt = 1'b1;
          src_nxt       = SRC_EXACT;
          colour_nxt    = rd_word_r.colour;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_ALT1;
        end
      end
      ST_ALT1: begin
        mem_raddr = alt2_r;
        if (rd_word_r.valid) begin
          out_valid_nxt = 1'b1;
          src_nxt       = SRC_FIRST;
          colour_nxt    = rd_word_r.colour;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_ALT2;
        end
      end
      ST_ALT2: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (rd_word_r.valid) begin
          src_nxt    = SRC_SECOND;
          colour_nxt = rd_word_r.colour;
        end else begin
          src_nxt    = SRC_DEFAULT;
          colour_nxt = dflt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      map24_r     <= MAP_2_TO_4_RST;
      map28_r     <= MAP_2_TO_8_RST;
      map48_lo_r  <= MAP_4_TO_8_LOW_RST;
      map48_hi_r  <= MAP_4_TO_8_HI_RST;
      out_valid_r <= 1'b0;
      src_r       <= SRC_DEFAULT;
      colour_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      src_r       <= src_nxt;
      colour_r    <= colour_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_2_TO_4:     map24_r    <= cfg_wdata[15:0];
          CFG_MAP_2_TO_8:     map28_r    <= cfg_wdata[31:0];
          CFG_MAP_4_TO_8_LOW: map48_lo_r <= cfg_wdata;
          CFG_MAP_4_TO_8_HI:  map48_hi_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      depth_r <= in_depth_code;
      idx_r   <= in_entry_index;
      alt1_r  <= alt1_addr;
      alt2_r  <= alt2_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      clut_mem[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= clut_mem[mem_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_colour_source = src_r;
  assign {out_alpha, out_blue, out_green, out_red} = colour_r;

endmodule

// File: rtl/core/sclut_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the subtitle colour lookup unit, bound to the top level.
// Depends on sclut_pkg.

module sclut_checker
  import sclut_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_operation,
  input logic [1:0] in_depth_code,
  input logic [7:0] in_entry_index,
  input logic [7:0] in_red,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha,
  input logic [1:0] out_colour_source
);

  logic lookup_acc;
  logic write_acc;

  assign lookup_acc = start && !busy && (in_operation == OP_LOOKUP);
  assign write_acc  = start && !busy && (in_operation == OP_WRITE);

  a_busy_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_acc && (in_depth_code != DEPTH_NONE)) |=> busy)
    else $error("table lookup transaction did not hold busy");

  a_result_per_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_acc && (in_depth_code != DEPTH_NONE)) |-> ##[2:4] out_valid)
    else $error("lookup transaction gave no result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    write_acc |=> !out_valid)
    else $error("result following a write transaction");

  a_bad_depth_black: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_acc && (in_depth_code == DEPTH_NONE)) |=>
      out_valid && (out_colour_source == SRC_DEFAULT) && (out_red == 8'd0) &&
      (out_alpha == 8'd0))
    else $error("depth code three lookup not transparent default");

  a_write_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (write_acc && (in_depth_code == DEPTH_TWO)) ##1
      (lookup_acc && (in_depth_code == DEPTH_TWO) &&
       (in_entry_index[1:0] == $past(in_entry_index[1:0]))) |=> ##1
      (out_valid && (out_colour_source == SRC_EXACT) && (out_red == $past(in_red, 3))))
    else $error("written entry not returned by following lookup");

endmodule

bind subtitle_clut_lookup_with_fallback_unit sclut_checker u_sclut_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .in_depth_code     (in_depth_code),
  .in_entry_index    (in_entry_index),
  .in_red            (in_red),
  .out_valid         (out_valid),
  .out_red           (out_red),
  .out_alpha         (out_alpha),
  .out_colour_source (out_colour_source)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for subtitle_clut_lookup_with_fallback_unit: drives table writes, lookups and
// map register writes, predicts each resolved colour and checks it against the result port.
// Depends on sclut_pkg and the unit under test.

module tb;
  import sclut_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_colour_t;

  typedef struct packed {
    rgba_colour_t colour;
    logic [1:0]   source;
  } resolved_colour_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = OP_LOOKUP;
  logic [1:0]  in_depth_code = DEPTH_TWO;
  logic [7:0]  in_entry_index = 8'd0;
  logic [7:0]  in_red = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_blue = 8'd0;
  logic [7:0]  in_alpha = 8'd0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAP_2_TO_4;
  logic [63:0] cfg_wdata = 64'd0;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [1:0]  out_colour_source;

  // predictor state
  rgba_colour_t colours_two[4];
  rgba_colour_t colours_four[16];
  rgba_colour_t colours_eight[256];
  logic         valid_two[4];
  logic         valid_four[16];
  logic         valid_eight[256];
  logic [15:0]  map_two_four = MAP_2_TO_4_RST;
  logic [31:0]  map_two_eight = MAP_2_TO_8_RST;
  logic [63:0]  map_four_eight_lo = MAP_4_TO_8_LOW_RST;
  logic [63:0]  map_four_eight_hi = MAP_4_TO_8_HI_RST;

  resolved_colour_t pending_colours[$];

  int unsigned mismatches = 0;
  int unsigned accepted_cmds = 0;
  int unsigned checked_results = 0;
  int unsigned map_writes = 0;
  int unsigned source_hits[4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;
  int unsigned calm_left = 0;
  logic [7:0]  recent_index = 8'd0;

  subtitle_clut_lookup_with_fallback_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_depth_code    (in_depth_code),
    .in_entry_index   (in_entry_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_colour_source(out_colour_source)
  );

  always #2 clk = ~clk;

  initial begin
    for (int k = 0; k < 4; k++) valid_two[k] = 1'b0;
    for (int k = 0; k < 16; k++) valid_four[k] = 1'b0;
    for (int k = 0; k < 256; k++) valid_eight[k] = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] pct_level(int unsigned p);
    return 8'((255 * p) / 100);
  endfunction

  function automatic rgba_colour_t pct_colour(int unsigned r, int unsigned g, int unsigned b,
                                              int unsigned transparency);
    rgba_colour_t c;
    c.red   = pct_level(r);
    c.green = pct_level(g);
    c.blue  = pct_level(b);
    c.alpha = pct_level(100 - transparency);
    return c;
  endfunction

  function automatic rgba_colour_t standard_two(logic [1:0] k);
    rgba_colour_t c;
    case (k)
      2'd0:    c = pct_colour(0, 0, 0, 100);
      2'd1:    c = pct_colour(100, 100, 100, 0);
      2'd2:    c = pct_colour(0, 0, 0, 0);
      default: c = pct_colour(50, 50, 50, 0);
    endcase
    return c;
  endfunction

  function automatic rgba_colour_t standard_four(logic [3:0] k);
    int unsigned lvl;
    if (k == 4'd0) return pct_colour(0, 0, 0, 100);
    lvl = k[3] ? 50 : 100;
    return pct_colour(lvl * k[0], lvl * k[1], lvl * k[2], 0);
  endfunction

  function automatic rgba_colour_t standard_eight(logic [7:0] k);
    int unsigned half;
    if (k == 8'd0) return pct_colour(0, 0, 0, 100);
    if (k[7:3] == 5'd0) return pct_colour(100 * k[0], 100 * k[1], 100 * k[2], 75);
    if (!k[7]) begin
      return pct_colour(33 * k[0] + 67 * k[4], 33 * k[1] + 67 * k[5],
                        33 * k[2] + 67 * k[6], k[3] ? 50 : 0);
    end
    half = k[3] ? 0 : 50;
    return pct_colour(17 * k[0] + 33 * k[4] + half, 17 * k[1] + 33 * k[5] + half,
                      17 * k[2] + 33 * k[6] + half, 0);
  endfunction

  // 4-bit code folded onto the 2-bit table
  function automatic logic [1:0] fold_to_two(logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0:    r = 2'd0;
      4'd8:    r = 2'd2;
      default: r = k[3] ? 2'd3 : 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic read_table(logic [1:0] depth, logic [7:0] idx,
                                      output rgba_colour_t c);
    case (depth)
      DEPTH_TWO: begin
        c = colours_two[idx[1:0]];
        return valid_two[idx[1:0]];
      end
      DEPTH_FOUR: begin
        c = colours_four[idx[3:0]];
        return valid_four[idx[3:0]];
      end
      default: begin
        c = colours_eight[idx];
        return valid_eight[idx];
      end
    endcase
  endfunction

  function automatic resolved_colour_t resolve_lookup(logic [1:0] depth, logic [7:0] idx);
    resolved_colour_t res;
    rgba_colour_t     fallback;
    rgba_colour_t     c;
    logic [1:0]       d1;
    logic [1:0]       d2;
    logic [7:0]       i1;
    logic [7:0]       i2;
    logic [63:0]      half_map;
    res.colour = '0;
    res.source = SRC_DEFAULT;
    if (depth == DEPTH_NONE) return res;
    if (read_table(depth, idx, c)) begin
      res.colour = c;
      res.source = SRC_EXACT;
      return res;
    end
    case (depth)
      DEPTH_TWO: begin
        d1 = DEPTH_FOUR;
        i1 = {4'h0, map_two_four[4 * idx[1:0] +: 4]};
        d2 = DEPTH_EIGHT;
        i2 = map_two_eight[8 * idx[1:0] +: 8];
        fallback = standard_two(idx[1:0]);
      end
      DEPTH_FOUR: begin
        half_map = idx[3] ? map_four_eight_hi : map_four_eight_lo;
        d1 = DEPTH_EIGHT;
        i1 = half_map[8 * idx[2:0] +: 8];
        d2 = DEPTH_TWO;
        i2 = {6'd0, fold_to_two(idx[3:0])};
        fallback = standard_four(idx[3:0]);
      end
      default: begin
        d1 = DEPTH_FOUR;
        i1 = {4'h0, idx[3:0]};
        d2 = DEPTH_TWO;
        i2 = {6'd0, fold_to_two(idx[3:0])};
        fallback = standard_eight(idx);
      end
    endcase
    if (read_table(d1, i1, c)) begin
      res.colour = c;
      res.source = SRC_FIRST;
    end else if (read_table(d2, i2, c)) begin
      res.colour = c;
      res.source = SRC_SECOND;
    end else begin
      res.colour = fallback;
      res.source = SRC_DEFAULT;
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // accepted transactions update the predictor; results are checked in order
  always @(posedge clk) begin : track
    resolved_colour_t want;
    rgba_colour_t     w;
    if (rst_n && cfg_we) begin
      map_writes++;
      case (cfg_index)
        CFG_MAP_2_TO_4:     map_two_four = cfg_wdata[15:0];
        CFG_MAP_2_TO_8:     map_two_eight = cfg_wdata[31:0];
        CFG_MAP_4_TO_8_LOW: map_four_eight_lo = cfg_wdata;
        default:            map_four_eight_hi = cfg_wdata;
      endcase
    end
    if (rst_n && start && !busy) begin
      accepted_cmds++;
      if (in_operation == OP_WRITE) begin
        w = {in_alpha, in_blue, in_green, in_red};
        case (in_depth_code)
          DEPTH_TWO: begin
            colours_two[in_entry_index[1:0]] = w;
            valid_two[in_entry_index[1:0]] = 1'b1;
          end
          DEPTH_FOUR: begin
            colours_four[in_entry_index[3:0]] = w;
            valid_four[in_entry_index[3:0]] = 1'b1;
          end
          DEPTH_EIGHT: begin
            colours_eight[in_entry_index] = w;
            valid_eight[in_entry_index] = 1'b1;
          end
          default: ;
        endcase
      end else begin
        want = resolve_lookup(in_depth_code, in_entry_index);
        source_hits[want.source]++;
        pending_colours.push_back(want);
      end
    end
    if (rst_n && out_valid) begin
      if (pending_colours.size() == 0) begin
        $error("colour result with no lookup outstanding: rgba %02h%02h%02h%02h source %0d",
               out_alpha, out_blue, out_green, out_red, out_colour_source);
        mismatches++;
      end else begin
        want = pending_colours.pop_front();
        checked_results++;
        check_field("out_red", want.colour.red, out_red);
        check_field("out_green", want.colour.green, out_green);
        check_field("out_blue", want.colour.blue, out_blue);
        check_field("out_alpha", want.colour.alpha, out_alpha);
        check_field("out_colour_source", want.source, out_colour_source);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(logic op, logic [1:0] depth, logic [7:0] idx, logic [31:0] rgba);
    int unsigned gap;
    in_operation   <= op;
    in_depth_code  <= depth;
    in_entry_index <= idx;
    in_red         <= rgba[7:0];
    in_green       <= rgba[15:8];
    in_blue        <= rgba[23:16];
    in_alpha       <= rgba[31:24];
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
  endtask

  // writes never give a result, so allow a few cycles beyond the last lookup
  task automatic settle_block();
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic program_maps(logic [15:0] m24, logic [31:0] m28, logic [63:0] lo,
                              logic [63:0] hi);
    logic [63:0] vals[4];
    logic [1:0]  regs[4];
    vals = '{{48'd0, m24}, {32'd0, m28}, lo, hi};
    regs = '{CFG_MAP_2_TO_4, CFG_MAP_2_TO_8, CFG_MAP_4_TO_8_LOW, CFG_MAP_4_TO_8_HI};
    for (int k = 0; k < 4; k++) begin
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      cfg_we    <= 1'b1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned n_items, int unsigned write_pct,
                                int unsigned narrow_pct);
    logic        op;
    logic [1:0]  depth;
    logic [7:0]  idx;
    int unsigned r;
    for (int unsigned k = 0; k < n_items; k++) begin
      op  = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_LOOKUP;
      idx = 8'($urandom);
      if (op == OP_WRITE) begin
        r = $urandom_range(0, 99);
        if (r < 5) depth = DEPTH_NONE;
        else if (r < 5 + narrow_pct) depth = $urandom_range(0, 1) ? DEPTH_FOUR : DEPTH_TWO;
        else depth = DEPTH_EIGHT;
        recent_index = idx;
      end else begin
        depth = ($urandom_range(0, 15) == 0) ? DEPTH_NONE : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) idx = recent_index;
      end
      send(op, depth, idx, $urandom);
      if ($urandom_range(0, 99) == 0) wait_results();
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_tables();
    send(OP_LOOKUP, DEPTH_NONE, 8'hAA, 32'h0);
    send(OP_WRITE, DEPTH_NONE, 8'h05, 32'hFFFF_FFFF);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h05, 32'h0);
    for (int k = 0; k < 4; k++) send(OP_LOOKUP, DEPTH_TWO, 8'(k), 32'h0);
    send(OP_LOOKUP, DEPTH_FOUR, 8'h00, 32'h0);
    send(OP_LOOKUP, DEPTH_FOUR, 8'hF9, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h00, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h07, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h38, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h77, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'hF0, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h88, 32'h0);
  endtask

  task automatic test_fallback_chain();
    // masked index and an all-zero colour still mark the entry valid
    send(OP_WRITE, DEPTH_FOUR, 8'hF7, 32'h0000_0000);
    send(OP_LOOKUP, DEPTH_FOUR, 8'h07, 32'h0);
    send(OP_LOOKUP, DEPTH_TWO, 8'h01, 32'h0);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'h17, 32'h0);
    send(OP_WRITE, DEPTH_TWO, 8'hFE, 32'h8040_2010);
    send(OP_LOOKUP, DEPTH_FOUR, 8'h08, 32'h0);
    send(OP_WRITE, DEPTH_EIGHT, 8'hFF, 32'hFFFF_FFFF);
    send(OP_LOOKUP, DEPTH_EIGHT, 8'hFF, 32'h0);
    send(OP_LOOKUP, DEPTH_TWO, 8'h03, 32'h0);
  endtask

  task automatic test_map_extremes();
    settle_block();
    program_maps('0, '0, '0, '0);
    random_traffic(120, 10, 5);
    settle_block();
    program_maps('1, '1, '1, '1);
    random_traffic(150, 25, 10);
  endtask

  task automatic test_random_maps();
    repeat (3) begin
      settle_block();
      program_maps(16'($urandom), $urandom, {$urandom, $urandom}, {$urandom, $urandom});
      random_traffic(150, 35, 30);
    end
  endtask

  task automatic test_reset_maps();
    settle_block();
    program_maps(MAP_2_TO_4_RST, MAP_2_TO_8_RST, MAP_4_TO_8_LOW_RST, MAP_4_TO_8_HI_RST);
    random_traffic(130, 40, 40);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_tables();
    test_fallback_chain();
    test_map_extremes();
    test_random_maps();
    test_reset_maps();
    settle_block();
    repeat (8) @(posedge clk);
    if (pending_colours.size() != 0) begin
      $error("%0d colour results never arrived", pending_colours.size());
      mismatches++;
    end
    $display("Run covered %0d transactions in, %0d colour results checked, %0d map writes.",
             accepted_cmds, checked_results, map_writes);
    $display("Sources seen: exact %0d, first alternate %0d, second alternate %0d, default %0d.",
             source_hits[0], source_hits[1], source_hits[2], source_hits[3]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
